>>> src/lsm_pkg.sv
// lsm_pkg: shared constants and types for the line substring matcher
// no dependencies; imported by the interfaces and all lsm modules
package lsm_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 6;
  localparam int LINE_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_REGS   = 4;
  localparam int PAT_BYTES  = PAT_REGS * CFG_DATA_W / BYTE_W;
  localparam int PAT_IDX_W  = $clog2(PAT_BYTES);

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
  localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_3 = 3'd4;

  typedef logic [BYTE_W-1:0] byte_t;

  // window control from the line engine
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

endpackage

>>> src/lsm_in_if.sv
// lsm_in_if: request channel carrying one text byte per request
// depends on lsm_pkg
interface lsm_in_if;
  import lsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] ch;
  logic              is_last;

  modport source (output valid, ch, is_last, input ready);
  modport sink   (input valid, ch, is_last, output ready);
endinterface

>>> src/lsm_out_if.sv
// lsm_out_if: result channel carrying one line verdict per request
// depends on lsm_pkg
interface lsm_out_if;
  import lsm_pkg::*;

  logic              valid;
  logic              ready;
  logic              matched;
  logic [LINE_W-1:0] line_index;

  modport source (output valid, matched, line_index, input ready);
  modport sink   (input valid, matched, line_index, output ready);
endinterface

>>> src/lsm_cfg_regs.sv
// lsm_cfg_regs: pattern configuration registers and the aligned compare image
// depends on lsm_pkg
module lsm_cfg_regs #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           cfg_we,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]                  cfg_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]                 cfg_data,
  output logic [MAX_PATTERN-1:0][lsm_pkg::BYTE_W-1:0]    cmp_bytes,
  output logic [MAX_PATTERN-1:0]                         cmp_mask,
  output logic                                           cmp_en,
  output logic [lsm_pkg::LEN_W-1:0]                      cmp_len
);
  import lsm_pkg::*;

  logic [LEN_W-1:0]                        len_r;
  logic [PAT_REGS-1:0][CFG_DATA_W-1:0]     pat_r;
  logic [PAT_BYTES-1:0][BYTE_W-1:0]        pat_bytes;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0]      cmp_bytes_r, cmp_bytes_nxt;
  logic [MAX_PATTERN-1:0]                  cmp_mask_r, cmp_mask_nxt;
  logic                                    cmp_en_r, cmp_en_nxt;
  logic [LEN_W-1:0]                        cmp_len_r;

  assign pat_bytes = pat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pat_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH:  len_r    <= cfg_data[LEN_W-1:0];
        REG_PATTERN_BYTES_0: pat_r[0] <= cfg_data;
        REG_PATTERN_BYTES_1: pat_r[1] <= cfg_data;
        REG_PATTERN_BYTES_2: pat_r[2] <= cfg_data;
        REG_PATTERN_BYTES_3: pat_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // window entry k (0 = newest) must equal pattern byte len-1-k
  always_comb begin
    logic [LEN_W-1:0] src;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      src             = len_r - LEN_W'(k) - LEN_W'(1);
      cmp_mask_nxt[k] = LEN_W'(k) < len_r;
      cmp_bytes_nxt[k] = pat_bytes[src[PAT_IDX_W-1:0]];
    end
    cmp_en_nxt = (len_r != '0) && (len_r <= LEN_W'(MAX_PATTERN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmp_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_bytes_r <= cmp_bytes_nxt;
    cmp_mask_r  <= cmp_mask_nxt;
    cmp_len_r   <= len_r;
  end

  assign cmp_bytes = cmp_bytes_r;
  assign cmp_mask  = cmp_mask_r;
  assign cmp_en    = cmp_en_r;
  assign cmp_len   = cmp_len_r;

endmodule

>>> src/lsm_window.sv
// lsm_window: window of recent line bytes, in-line byte count and parallel compare
// depends on lsm_pkg
module lsm_window #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  lsm_pkg::win_ctl_t                           ctl,
  input  logic [lsm_pkg::BYTE_W-1:0]                  ch,
  input  logic [MAX_PATTERN-1:0][lsm_pkg::BYTE_W-1:0] cmp_bytes,
  input  logic [MAX_PATTERN-1:0]                      cmp_mask,
  input  logic                                        cmp_en,
  input  logic [lsm_pkg::LEN_W-1:0]                   cmp_len,
  output logic                                        hit
);
  import lsm_pkg::*;

  localparam int SEEN_W = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_r, window_nxt;
  logic [SEEN_W-1:0]                  seen_r, seen_nxt, seen_inc;
  logic [MAX_PATTERN-1:0]             byte_ok;

  // window as it stands once ch is shifted in
  always_comb begin
    window_nxt[0] = ch;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_nxt[k] = window_r[k-1];
    end
  end

  assign seen_inc = (seen_r == SEEN_W'(MAX_PATTERN)) ? seen_r : seen_r + SEEN_W'(1);

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      byte_ok[k] = !cmp_mask[k] || (window_nxt[k] == cmp_bytes[k]);
    end
  end

  assign hit = cmp_en && (LEN_W'(seen_inc) >= cmp_len) && (&byte_ok);

  always_comb begin
    seen_nxt = seen_r;
    if (ctl.clear) begin
      seen_nxt = '0;
    end else if (ctl.shift) begin
      seen_nxt = seen_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      window_r <= window_nxt;
    end
  end

endmodule

>>> src/line_substring_matcher_unit.sv
// line_substring_matcher_unit: reports per text line whether the pattern occurs in it
// a line verdict is registered when its closing byte leaves the input register
// throughput: one byte per cycle; intake stalls only while a line-ending byte waits
//   behind a verdict that the result register still holds
// reset: synchronous active-low rst_n clears pattern, counters, flags and both channels
// depends on lsm_pkg, lsm_in_if, lsm_out_if, lsm_cfg_regs, lsm_window
module line_substring_matcher_unit #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lsm_in_if.sink                          in_req,
  lsm_out_if.source                       out_res,
  input  logic                            cfg_we,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsm_pkg::*;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] cmp_bytes;
  logic [MAX_PATTERN-1:0]             cmp_mask;
  logic                               cmp_en;
  logic [LEN_W-1:0]                   cmp_len;
  logic                               hit;
  win_ctl_t                           win_ctl;

  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_ch_r;
  logic              in_last_r;
  logic              found_r, found_nxt;
  logic              stopped_r, stopped_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_matched_r;
  logic [LINE_W-1:0] out_line_r;

  logic ends, take, stop_set, advance, accept, found_cur;

  lsm_cfg_regs #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmp_bytes (cmp_bytes),
    .cmp_mask  (cmp_mask),
    .cmp_en    (cmp_en),
    .cmp_len   (cmp_len)
  );

  lsm_window #(.MAX_PATTERN(MAX_PATTERN)) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl),
    .ch        (in_ch_r),
    .cmp_bytes (cmp_bytes),
    .cmp_mask  (cmp_mask),
    .cmp_en    (cmp_en),
    .cmp_len   (cmp_len),
    .hit       (hit)
  );

  assign ends     = in_last_r || (in_ch_r == NEWLINE_BYTE);
  assign take     = (in_ch_r != NEWLINE_BYTE) && !stopped_r && (in_ch_r != ZERO_BYTE);
  assign stop_set = (in_ch_r != NEWLINE_BYTE) && !stopped_r && (in_ch_r == ZERO_BYTE);
  assign found_cur = found_r || (take && hit);

  // a line-ending byte needs the result register free or draining
  assign advance = in_valid_r && (!ends || !out_valid_r || out_res.ready);
  assign accept  = in_req.valid && in_req.ready;

  assign win_ctl.shift = advance && take;
  assign win_ctl.clear = advance && ends;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    found_nxt     = found_r;
    stopped_nxt   = stopped_r;
    line_nxt      = line_r;
    out_valid_nxt = out_valid_r;
    if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      in_valid_nxt = 1'b0;
      if (ends) begin
        found_nxt     = 1'b0;
        stopped_nxt   = 1'b0;
        line_nxt      = line_r + LINE_W'(1);
        out_valid_nxt = 1'b1;
      end else begin
        found_nxt   = found_cur;
        stopped_nxt = stopped_r || stop_set;
      end
    end
    if (accept) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      stopped_r   <= 1'b0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      found_r     <= found_nxt;
      stopped_r   <= stopped_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_ch_r   <= in_req.ch;
      in_last_r <= in_req.is_last;
    end
    if (advance && ends) begin
      out_matched_r <= found_cur;
      out_line_r    <= line_r;
    end
  end

  assign in_req.ready       = !in_valid_r || advance;
  assign out_res.valid      = out_valid_r;
  assign out_res.matched    = out_matched_r;
  assign out_res.line_index = out_line_r;

endmodule

>>> test/testbench.sv
// testbench for line_substring_matcher_unit: byte stream in, one verdict per line out
// depends on lsm_pkg, lsm_in_if, lsm_out_if and the unit itself; checks against
// a line-by-line prediction under random stalls on both channels
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lsm_pkg::*;

  localparam int WINDOW_DEPTH = 32;
  localparam int TARGET_BYTES = 1200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic              matched;
    logic [LINE_W-1:0] line_index;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lsm_in_if  in_ch();
  lsm_out_if out_ch();

  line_substring_matcher_unit #(.MAX_PATTERN(WINDOW_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line predictor state, updated from what the unit actually accepts
  logic [LEN_W-1:0]      model_len;
  logic [CFG_DATA_W-1:0] model_pat [PAT_REGS];
  byte_t                 recent [WINDOW_DEPTH];
  int                    line_fill;
  bit                    line_hit;
  bit                    line_halted;
  logic [LINE_W-1:0]     line_count;
  verdict_t              expected_verdicts [$];

  // stimulus side
  int    stim_len;
  byte_t stim_pat [WINDOW_DEPTH];
  bit    no_gaps = 1'b0;
  int    stall_left = 0;
  int    idle_cycles = 0;
  int    fail_count = 0;
  int    bytes_taken = 0;
  int    lines_checked = 0;
  int    lines_matched = 0;
  int    cfg_settings = 0;

  function automatic bit window_holds_pattern();
    int n;
    int j;
    n = model_len;
    if (n == 0 || n > WINDOW_DEPTH || line_fill < n) return 1'b0;
    for (j = 0; j < n; j++) begin
      if (model_pat[j / 8][(j % 8) * 8 +: 8] != recent[n - 1 - j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_line_verdict(input byte_t c, input bit last);
    verdict_t v;
    int k;
    if (c != NEWLINE_BYTE && !line_halted) begin
      if (c == ZERO_BYTE) begin
        line_halted = 1'b1;
      end else begin
        for (k = WINDOW_DEPTH - 1; k > 0; k--) recent[k] = recent[k - 1];
        recent[0] = c;
        if (line_fill < WINDOW_DEPTH) line_fill++;
        if (window_holds_pattern()) line_hit = 1'b1;
      end
    end
    if (last || c == NEWLINE_BYTE) begin
      v.matched    = line_hit;
      v.line_index = line_count;
      expected_verdicts.push_back(v);
      line_count  = line_count + 1'b1;
      line_fill   = 0;
      line_hit    = 1'b0;
      line_halted = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      model_len = '0;
      foreach (model_pat[i]) model_pat[i] = '0;
      foreach (recent[i]) recent[i] = '0;
      line_fill   = 0;
      line_hit    = 1'b0;
      line_halted = 1'b0;
      line_count  = '0;
      expected_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LENGTH:  model_len    = cfg_data[LEN_W-1:0];
          REG_PATTERN_BYTES_0: model_pat[0] = cfg_data;
          REG_PATTERN_BYTES_1: model_pat[1] = cfg_data;
          REG_PATTERN_BYTES_2: model_pat[2] = cfg_data;
          REG_PATTERN_BYTES_3: model_pat[3] = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        lines_checked++;
        if (out_ch.matched === 1'b1) lines_matched++;
        if (expected_verdicts.size() == 0) begin
          $error("verdict with no line pending: line_index %0d", out_ch.line_index);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, out_ch.matched);
            fail_count++;
          end
          if (out_ch.line_index !== want.line_index) begin
            $error("line_index: expected %0d, got %0d", want.line_index, out_ch.line_index);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_taken++;
        predict_line_verdict(in_ch.ch, in_ch.is_last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL line_substring_matcher_unit");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // result side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic send_byte(input byte_t c, input bit last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.ch      <= c;
    in_ch.is_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_str(input string s, input bit last_at_end);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]), last_at_end && i == s.len() - 1);
  endtask

  // let the unit settle so register writes land while it is idle
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_pattern();
    logic [CFG_DATA_W-1:0] word;
    int k;
    int j;
    // upper bits of the length word are junk and must be dropped
    word = {$urandom, $urandom};
    word[LEN_W-1:0] = stim_len[LEN_W-1:0];
    write_reg(REG_PATTERN_LENGTH, word);
    for (k = 0; k < PAT_REGS; k++) begin
      for (j = 0; j < 8; j++) word[j * 8 +: 8] = stim_pat[k * 8 + j];
      write_reg(CFG_IDX_W'(REG_PATTERN_BYTES_0 + k), word);
    end
    cfg_settings++;
  endtask

  function automatic byte_t text_byte();
    if ($urandom_range(0, 9) < 7) return byte_t'("a" + $urandom_range(0, 2));
    return byte_t'($urandom_range(1, 255));
  endfunction

  task automatic pick_pattern(input int forced_len);
    int r;
    r = $urandom_range(0, 99);
    if (forced_len >= 0) stim_len = forced_len;
    else if (r < 5) stim_len = 0;
    else if (r < 45) stim_len = $urandom_range(1, 4);
    else if (r < 75) stim_len = $urandom_range(5, 16);
    else if (r < 85) stim_len = $urandom_range(17, WINDOW_DEPTH - 1);
    else if (r < 93) stim_len = WINDOW_DEPTH;
    else stim_len = $urandom_range(WINDOW_DEPTH + 1, 63);
    foreach (stim_pat[i]) begin
      r = $urandom_range(0, 99);
      if (r < 90) stim_pat[i] = byte_t'("a" + $urandom_range(0, 2));
      else if (r < 98) stim_pat[i] = byte_t'($urandom_range(1, 255));
      else stim_pat[i] = ZERO_BYTE;
    end
  endtask

  // noise, then maybe the pattern or a near miss, then noise, then a line end; a body byte may become zero
  task automatic send_random_line();
    byte_t body [$];
    int    n;
    int    i;
    int    plen;
    int    r;
    plen = (stim_len > WINDOW_DEPTH) ? WINDOW_DEPTH : stim_len;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
    repeat (n) body.push_back(text_byte());
    if (plen > 0 && $urandom_range(0, 1) == 1) begin
      for (i = 0; i < plen; i++) body.push_back(stim_pat[i]);
      if ($urandom_range(0, 6) == 0) body[body.size() - 1 - $urandom_range(0, plen - 1)] = text_byte();
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
    repeat (n) body.push_back(text_byte());
    if (body.size() > 0 && $urandom_range(0, 9) == 0) begin
      body[$urandom_range(0, body.size() - 1)] = ZERO_BYTE;
    end
    foreach (body[k]) send_byte(body[k], 1'b0);
    r = $urandom_range(0, 99);
    if (r < 80) send_byte(NEWLINE_BYTE, 1'b0);
    else if (r < 88) send_byte(NEWLINE_BYTE, 1'b1);
    else send_byte(text_byte(), 1'b1);
  endtask

  // pattern length is zero after reset, so nothing may match
  task automatic test_empty_pattern();
    send_str("a\n", 1'b0);
    send_str("\n", 1'b0);
  endtask

  task automatic test_short_pattern();
    wait_idle();
    pick_pattern(2);
    stim_pat[0] = byte_t'("a");
    stim_pat[1] = byte_t'("b");
    load_pattern();
    send_str("xab\n", 1'b0);
    // last flag ends a line, the next byte opens a new one
    send_str("a", 1'b1);
    send_str("ab", 1'b1);
    send_str("\n", 1'b1);
    send_byte(ZERO_BYTE, 1'b0);
    send_str("ab\n", 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b0);
  endtask

  task automatic test_ignored_registers();
    int idx;
    wait_idle();
    for (idx = REG_PATTERN_BYTES_3 + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), {$urandom, $urandom});
    end
    send_str("ab\n", 1'b0);
  endtask

  task automatic test_oversize_length();
    wait_idle();
    stim_len = WINDOW_DEPTH + 1;
    load_pattern();
    send_str("ab\n", 1'b0);
  endtask

  task automatic test_random_lines();
    int start;
    int round;
    start = bytes_taken;
    round = 0;
    while (bytes_taken - start < TARGET_BYTES) begin
      wait_idle();
      case (round)
        0:       pick_pattern(WINDOW_DEPTH);
        1:       pick_pattern(63);
        2:       pick_pattern(1);
        default: pick_pattern(-1);
      endcase
      load_pattern();
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 14)) send_random_line();
      round++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.ch      = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready  = 1'b0;
    stim_len      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pattern();
    test_short_pattern();
    test_ignored_registers();
    test_oversize_length();
    test_random_lines();

    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d text bytes over %0d pattern settings, lengths 0 to 63 incl. full window",
             bytes_taken, cfg_settings + 1);
    $display("%0d line verdicts checked, %0d of them matched", lines_checked, lines_matched);
    if (fail_count == 0) begin
      $display("PASS line_substring_matcher_unit");
    end else begin
      $display("FAIL line_substring_matcher_unit");
    end
    $finish;
  end

endmodule
